// ----- rtl/core/sdes_pkg.sv -----
// Package: S-box tables and round helpers for the 12-bit simplified DES core.
`timescale 1ns / 1ps

package sdes_pkg;

  localparam int KEY_W   = 9;
  localparam int RKEY_W  = 8;
  localparam int HALF_W  = 6;
  localparam int BLOCK_W = 12;
  localparam int RC_W    = 4;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [RKEY_W-1:0]  rkey_t;
  typedef logic [KEY_W-1:0]   mkey_t;
  typedef logic [RC_W-1:0]    rcount_t;

  // configuration register indexes
  localparam logic REG_MASTER_KEY  = 1'b0;
  localparam logic REG_ROUND_COUNT = 1'b1;

  localparam logic [2:0] SBOX_HI [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };
  localparam logic [2:0] SBOX_LO [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  // expansion in bit order 1 2 4 3 4 3 5 6 (bit 1 = MSB of the half)
  function automatic rkey_t expand6(input half_t r);
    return {r[5], r[4], r[2], r[3], r[2], r[3], r[1], r[0]};
  endfunction

  function automatic half_t round_fn(input half_t r, input rkey_t k);
    rkey_t x;
    x = expand6(r) ^ k;
    return {SBOX_HI[x[7:4]], SBOX_LO[x[3:0]]};
  endfunction

  // top 8 bits of the master key rotated left by idx (idx in 0..8)
  function automatic rkey_t round_key(input mkey_t k, input rcount_t idx);
    logic [2*KEY_W-1:0] d;
    d = {k, k} << idx;
    return d[2*KEY_W-1:KEY_W+1];
  endfunction

  function automatic block_t one_round(input block_t b, input rkey_t k);
    return {b[HALF_W-1:0], round_fn(b[HALF_W-1:0], k) ^ b[BLOCK_W-1:HALF_W]};
  endfunction

endpackage

// ----- rtl/core/simplified_des_cipher_core.sv -----
// Top level: pipelined 12-bit simplified DES cipher, one round per stage.
`timescale 1ns / 1ps

//  channel   | ports                              | beat contents
//  ----------+------------------------------------+-------------------------------
//  input     | in_tvalid/in_tready/in_tdata/tuser | tdata: block_in, tuser: mode
//  result    | out_tvalid/out_tready/out_tdata    | tdata: block_out
//  config    | cfg_we/cfg_index/cfg_wdata         | 0 master_key, 1 round_count
//
//  The pipeline is an input register, then one register per Feistel round.
//  Rounds at or beyond round_count pass the block through.
//  One beat per cycle enters while the output side is ready; each stage has
//  its own valid bit and takes a beat when it is empty or its successor moves,
//  so bubbles are squeezed and a stalled output still lets upstream fill.
//  Reset (rst_n, synchronous) clears valid bits, master_key=0, round_count=4.

module simplified_des_cipher_core
  import sdes_pkg::*;
#(
  parameter int MAX_ROUNDS = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] block_in, [15:12] zero
  input  logic [0:0]  in_tuser,   // [0] mode (0 encrypt, 1 decrypt)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] block_out, [15:12] zero
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam rcount_t MAX_RC = RC_W'(MAX_ROUNDS);

  mkey_t   master_key_r;
  rcount_t round_count_r;

  // stage 0 holds the accepted beat; stage j+1 holds it after round j
  block_t blk_r  [MAX_ROUNDS+1];
  logic   mode_r [MAX_ROUNDS+1];
  logic   vld_r  [MAX_ROUNDS+1];
  logic   rdy    [MAX_ROUNDS+1];
  block_t blk_nxt[MAX_ROUNDS];

  // config: round counts above the maximum clamp to it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_key_r  <= '0;
      round_count_r <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASTER_KEY:  master_key_r <= cfg_wdata;
        REG_ROUND_COUNT: begin
          round_count_r <= (cfg_wdata[RC_W-1:0] > MAX_RC) ? MAX_RC : cfg_wdata[RC_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // per-stage ready: empty, or the next stage moves this cycle
  always_comb begin
    rdy[MAX_ROUNDS] = !vld_r[MAX_ROUNDS] || out_tready;
    for (int j = MAX_ROUNDS - 1; j >= 0; j--) begin
      rdy[j] = !vld_r[j] || rdy[j+1];
    end
  end

  assign in_tready = rdy[0];

  // round logic: key order reverses for decrypt
  always_comb begin
    for (int j = 0; j < MAX_ROUNDS; j++) begin
      rcount_t idx;
      idx = mode_r[j] ? (round_count_r - RC_W'(1) - RC_W'(j)) : RC_W'(j);
      if (RC_W'(j) < round_count_r) begin
        blk_nxt[j] = one_round(blk_r[j], round_key(master_key_r, idx));
      end else begin
        blk_nxt[j] = blk_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= MAX_ROUNDS; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int j = 0; j < MAX_ROUNDS; j++) begin
        if (rdy[j+1]) begin
          vld_r[j+1] <= vld_r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_tvalid) begin
      blk_r[0]  <= in_tdata[BLOCK_W-1:0];
      mode_r[0] <= in_tuser[0];
    end
    for (int j = 0; j < MAX_ROUNDS; j++) begin
      if (rdy[j+1] && vld_r[j]) begin
        blk_r[j+1]  <= blk_nxt[j];
        mode_r[j+1] <= mode_r[j];
      end
    end
  end

  // final half swap is wiring on the last stage
  assign out_tvalid = vld_r[MAX_ROUNDS];
  assign out_tdata  = {4'b0000, blk_r[MAX_ROUNDS][HALF_W-1:0],
                       blk_r[MAX_ROUNDS][BLOCK_W-1:HALF_W]};

endmodule

// ----- dv/tb_simplified_des_cipher_core.sv -----
// Self-checking testbench for the pipelined 12-bit simplified DES cipher core.
`timescale 1ns / 1ps

module tb_simplified_des_cipher_core
  import sdes_pkg::*;
();

  // Pipeline depth is MAX_ROUNDS+1 stages; settle time at the end covers it.
  localparam int PIPE_DEPTH  = 10;
  localparam int ROUNDS_MAX  = 9;
  // A normal run ends before this limit even with both sides stalling often.
  localparam int CYCLE_LIMIT = 200000;

  // --------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [11:0] block_in, [15:12] zero
  logic [0:0]  in_tuser;   // [0] mode (0 encrypt, 1 decrypt)
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [11:0] block_out, [15:12] zero
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_wdata;

  simplified_des_cipher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 4 ns period
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // --------------------------------------------------------------------
  // Cipher predictor: own copy of the tables and of the two registers
  // --------------------------------------------------------------------
  localparam logic [2:0] S1_TABLE [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };
  localparam logic [2:0] S2_TABLE [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  mkey_t   key_shadow;     // mirrors master_key
  rcount_t rounds_shadow;  // mirrors round_count, already clamped

  block_t  expected_blocks [$];  // predicted block_out, oldest first
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      cycle_count;

  // 6 -> 8 bit expansion, written with masks and shifts
  function automatic rkey_t widen_half(input half_t r);
    logic [7:0] v;
    v = {2'b00, r};
    return ((v & 8'h30) << 2) | ((v & 8'h04) << 3) | ((v & 8'h0C) << 1)
         | ((v & 8'h08) >> 1) | (v & 8'h03);
  endfunction

  function automatic half_t feistel_f(input half_t r, input rkey_t k);
    rkey_t x;
    x = widen_half(r) ^ k;
    return {S1_TABLE[x[7:4]], S2_TABLE[x[3:0]]};
  endfunction

  // true 9-bit left rotation, keep the top eight bits
  function automatic rkey_t subkey_for(input mkey_t k, input int idx);
    mkey_t rot;
    int    s;
    s   = idx % 9;
    rot = (s == 0) ? k : mkey_t'((k << s) | (k >> (9 - s)));
    return rot[8:1];
  endfunction

  function automatic block_t cipher_block(input logic decrypt, input block_t blk);
    block_t b;
    half_t  l;
    half_t  r;
    int     n;
    int     ki;
    b = blk;
    n = int'(rounds_shadow);
    for (int i = 0; i < n; i++) begin
      ki = decrypt ? (n - 1 - i) : i;
      l  = b[11:6];
      r  = b[5:0];
      b  = {r, l ^ feistel_f(r, subkey_for(key_shadow, ki))};
    end
    return {b[5:0], b[11:6]};  // closing half swap
  endfunction

  // --------------------------------------------------------------------
  // Mismatch reporting and result checking
  // --------------------------------------------------------------------
  task automatic report_mismatch(input string what, input block_t got, input block_t want);
    $display("MISMATCH %s: got 0x%03h expected 0x%03h at cycle %0d",
             what, got, want, cycle_count);
    error_count++;
  endtask

  // Sampled at the rising edge; out_tready only moves on the falling edge.
  always @(posedge clk) begin : check_results
    block_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[11:0], '0);
      end else begin
        want = expected_blocks.pop_front();
        if (out_tdata[11:0] !== want)
          report_mismatch("block_out", out_tdata[11:0], want);
        if (out_tdata[15:12] !== 4'h0)
          report_mismatch("tdata pad", {8'h00, out_tdata[15:12]}, '0);
      end
    end
  end

  // Receiver backpressure, one decision per cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------

  // One input beat. tvalid is left high on return so back-to-back beats
  // flow without a bubble; random gaps drop it for whole cycles.
  task automatic send_block(input logic mode, input block_t blk);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, blk};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    expected_blocks.push_back(cipher_block(mode, blk));
  endtask

  // Stop sending and wait until every predicted beat has come out.
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  // Register write; only called with the pipeline empty.
  task automatic write_reg(input logic idx, input logic [8:0] val);
    drain_pipeline();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_MASTER_KEY) begin
      key_shadow = val;
    end else begin
      rounds_shadow = (val[3:0] > ROUNDS_MAX) ? rcount_t'(ROUNDS_MAX) : val[3:0];
    end
  endtask

  task automatic set_rounds(input logic [3:0] n);
    write_reg(REG_ROUND_COUNT, {5'b0, n});
  endtask

  // --------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------

  // Reset values: key 0, four rounds.
  task automatic test_reset_defaults();
    send_block(1'b0, 12'h000);
    send_block(1'b1, 12'hFFF);
    drain_pipeline();
  endtask

  // No rounds at all: only the half swap is left.
  task automatic test_zero_rounds();
    write_reg(REG_MASTER_KEY, 9'h0A5);
    set_rounds(4'd0);
    send_block(1'b0, 12'hFC0);
    send_block(1'b1, 12'h03F);
    drain_pipeline();
  endtask

  // Counts above nine store nine; nine itself is the deepest setting.
  task automatic test_round_clamp();
    set_rounds(4'd15);
    send_block(1'b0, 12'hAAA);
    send_block(1'b1, 12'h555);
    set_rounds(4'd10);
    send_block(1'b0, 12'h555);
    send_block(1'b1, 12'hAAA);
    set_rounds(4'd9);
    send_block(1'b0, 12'hFFF);
    send_block(1'b1, 12'h000);
    drain_pipeline();
  endtask

  // Keys whose rotation wraps bits around the 9-bit boundary.
  task automatic test_key_rotation();
    write_reg(REG_MASTER_KEY, 9'h100);
    send_block(1'b0, 12'h123);
    send_block(1'b1, 12'hEDC);
    write_reg(REG_MASTER_KEY, 9'h001);
    send_block(1'b0, 12'h03F);
    send_block(1'b1, 12'hFC0);
    write_reg(REG_MASTER_KEY, 9'h1FF);
    set_rounds(4'd1);
    send_block(1'b0, 12'hFFF);
    send_block(1'b1, 12'h000);
    drain_pipeline();
  endtask

  // Random blocks under random settings. Some beats decrypt the previous
  // ciphertext so the round trip through the pipe gets exercised too.
  task automatic test_random_traffic(input int phases, input int beats,
                                     input int s_idle, input int r_idle);
    block_t last_out;
    logic   last_mode;
    logic   mode;
    block_t blk;
    int     pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int p = 0; p < phases; p++) begin
      pick = $urandom_range(7);
      if (pick == 0)      write_reg(REG_MASTER_KEY, 9'h000);
      else if (pick == 1) write_reg(REG_MASTER_KEY, 9'h1FF);
      else                write_reg(REG_MASTER_KEY, 9'($urandom_range(511)));
      set_rounds(4'($urandom_range(15)));
      last_mode = 1'b1;
      last_out  = '0;
      for (int i = 0; i < beats; i++) begin
        if (last_mode == 1'b0 && $urandom_range(3) == 0) begin
          mode = 1'b1;
          blk  = last_out;
        end else begin
          mode = 1'($urandom_range(1));
          blk  = 12'($urandom_range(4095));
        end
        send_block(mode, blk);
        last_mode = mode;
        last_out  = expected_blocks[$];
      end
    end
    drain_pipeline();
  endtask

  // --------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_MASTER_KEY;
    cfg_wdata     = '0;
    error_count   = 0;
    cycle_count   = 0;
    key_shadow    = '0;
    rounds_shadow = 4'd4;
    send_idle_pct = 16;
    recv_idle_pct = 48;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_rounds();
    test_round_clamp();
    test_key_rotation();

    test_random_traffic(7, 45, 16, 48);
    test_random_traffic(7, 45, 48, 16);
    test_random_traffic(7, 45, 0, 0);

    // let anything stray fall out of the pipe before judging
    recv_idle_pct = 0;
    repeat (PIPE_DEPTH + 5) @(posedge clk);

    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sdes_pkg.sv
rtl/core/simplified_des_cipher_core.sv
dv/tb_simplified_des_cipher_core.sv
